// ===== design/sli_pkg.sv =====
`timescale 1ns / 1ps
package sli_pkg;

  localparam int CW   = 16;       // input coordinate width
  localparam int DW   = CW + 1;   // coordinate difference
  localparam int PW   = 2 * DW;   // difference product
  localparam int SW   = PW + 1;   // cross product (wn, qpn, side tests)
  localparam int BMW  = CW + SW;  // base * wn
  localparam int DMW  = DW + SW;  // dir * qpn
  localparam int NUMW = DMW + 1;  // numerator
  localparam int QW   = 24;       // quotient bits kept
  localparam int OW   = 24;       // output coordinate width

  typedef enum logic [1:0] {
    OP_SEG_SEG   = 2'd0,
    OP_SEG_LINE  = 2'd1,
    OP_LINE_LINE = 2'd2,
    OP_NONE      = 2'd3
  } sli_op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [CW-1:0] first_a_x;
    logic signed [CW-1:0] first_a_y;
    logic signed [CW-1:0] first_b_x;
    logic signed [CW-1:0] first_b_y;
    logic signed [CW-1:0] second_a_x;
    logic signed [CW-1:0] second_a_y;
    logic signed [CW-1:0] second_b_x;
    logic signed [CW-1:0] second_b_y;
  } sli_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [OW-1:0] inter_x;
    logic signed [OW-1:0] inter_y;
    logic                 clipped;
  } sli_out_t;

  // sideband that walks along the divider cells
  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } sli_ctl_t;

endpackage

// ===== design/segment_line_intersector_unit.sv =====
`timescale 1ns / 1ps
// Segment / line intersection in the integer plane, one query per beat.
// Input channel: in_valid_i / in_stall_o with in_data_i (operation plus
// two point pairs). Output channel: out_valid_o / out_stall_i with
// out_data_o (hit, fixed point inter_x / inter_y, clipped).
// A beat moves when valid is high and stall is low.
// Path: an input beat passes through the prep stages (cross products,
// numerator products, rounding setup and overflow check), then a chain of
// 24 divider cells giving one quotient bit each, into the output register.
// Throughput: one beat per cycle while the skid register is empty; every stage then takes a new item each cycle.
// Stall: the whole pipe freezes while a result sits in the skid register;
// in_stall_o comes straight from that register, so input and output
// handshakes never form a combinational path.
// Reset: clears all valid bits, the output and skid flags included; no
// results are pending after reset and the block takes input at once.
// No hit gives zero coordinates and clipped low.
module segment_line_intersector_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sli_pkg::sli_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sli_pkg::sli_out_t out_data_o
);
  import sli_pkg::*;

  localparam int NW = NUMW + FRAC_BITS + 1;  // scaled numerator incl. rounding carry

  logic en;
  logic out_valid_q, skid_valid_q;
  sli_out_t out_q, skid_q, res;

  sli_ctl_t         ctl [QW+1];
  logic [NW-1:0]    rx  [QW+1];
  logic [NW-1:0]    ry  [QW+1];
  logic [QW-1:0]    qx  [QW+1];
  logic [QW-1:0]    qy  [QW+1];
  logic [SW-1:0]    dv  [QW+1];

  assign en = !skid_valid_q;

  sli_prep #(
    .FRAC_BITS(FRAC_BITS),
    .NW(NW)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .ctl_o  (ctl[0]),
    .nx_o   (rx[0]),
    .ny_o   (ry[0]),
    .d_o    (dv[0])
  );

  assign qx[0] = '0;
  assign qy[0] = '0;

  // quotient bits MSB first along the chain
  for (genvar k = 0; k < QW; k++) begin : g_cell
    sli_div_cell #(
      .NW(NW),
      .SHIFT(QW - 1 - k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctl_i (ctl[k]),
      .rx_i  (rx[k]),
      .ry_i  (ry[k]),
      .qx_i  (qx[k]),
      .qy_i  (qy[k]),
      .d_i   (dv[k]),
      .ctl_o (ctl[k+1]),
      .rx_o  (rx[k+1]),
      .ry_o  (ry[k+1]),
      .qx_o  (qx[k+1]),
      .qy_o  (qy[k+1]),
      .d_o   (dv[k+1])
    );
  end

  // saturate to the signed output range
  logic clip_x, clip_y;
  logic [QW-1:0] qfx, qfy;
  sli_ctl_t cl;

  assign cl  = ctl[QW];
  assign qfx = qx[QW];
  assign qfy = qy[QW];
  assign clip_x = cl.ovf_x || (cl.neg_x ? (qfx[QW-1] && (qfx[QW-2:0] != '0)) : qfx[QW-1]);
  assign clip_y = cl.ovf_y || (cl.neg_y ? (qfy[QW-1] && (qfy[QW-2:0] != '0)) : qfy[QW-1]);

  always_comb begin
    res = '0;
    if (cl.hit) begin
      res.hit = 1'b1;
      res.clipped = clip_x || clip_y;
      if (clip_x) res.inter_x = cl.neg_x ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      else        res.inter_x = cl.neg_x ? OW'(-qfx) : OW'(qfx);
      if (clip_y) res.inter_y = cl.neg_y ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      else        res.inter_y = cl.neg_y ? OW'(-qfy) : OW'(qfy);
    end
  end

  // output register plus skid
  logic take, push;
  assign take = out_valid_q && !out_stall_i;
  assign push = en && cl.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !take) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) out_q <= skid_q;
    end else if (push) begin
      if (out_valid_q && !take) skid_q <= res;
      else out_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while output register is empty");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |->
      (out_data_o.inter_x == '0 && out_data_o.inter_y == '0 && !out_data_o.clipped))
    else $error("miss result carries nonzero fields");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |=> $stable(ctl[QW].valid))
    else $error("pipe moved while skid was full");

endmodule

// ===== design/sli_prep.sv =====
`timescale 1ns / 1ps
module sli_prep #(
  parameter int FRAC_BITS = 8,
  parameter int NW        = 62
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  sli_pkg::sli_in_t data_i,
  output sli_pkg::sli_ctl_t ctl_o,
  output logic [NW-1:0]    nx_o,
  output logic [NW-1:0]    ny_o,
  output logic [sli_pkg::SW-1:0] d_o
);
  import sli_pkg::*;

  localparam int XW = NW + QW;

  function automatic logic straddle(input logic signed [SW-1:0] a,
                                    input logic signed [SW-1:0] b);
    return (a == '0) || (b == '0) || (a[SW-1] != b[SW-1]);
  endfunction

  // ---- stage 1: differences
  logic [7:0] vld_q;
  sli_op_e s1_op_q;
  logic signed [CW-1:0] s1_px_q, s1_py_q, s1_qx_q, s1_qy_q;
  logic signed [DW-1:0] s1_vx_q, s1_vy_q, s1_wx_q, s1_wy_q;
  logic signed [DW-1:0] s1_dpx_q, s1_dpy_q, s1_dbx_q, s1_dby_q, s1_dcx_q, s1_dcy_q;
  sli_op_e op_d;

  assign op_d = sli_op_e'(data_i.operation);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_op_q <= op_d;
      s1_px_q <= data_i.first_a_x;
      s1_py_q <= data_i.first_a_y;
      s1_qx_q <= data_i.second_a_x;
      s1_qy_q <= data_i.second_a_y;
      s1_vx_q <= (op_d == OP_LINE_LINE) ? DW'(data_i.first_b_x)
                 : DW'(data_i.first_b_x) - DW'(data_i.first_a_x);
      s1_vy_q <= (op_d == OP_LINE_LINE) ? DW'(data_i.first_b_y)
                 : DW'(data_i.first_b_y) - DW'(data_i.first_a_y);
      s1_wx_q <= (op_d == OP_SEG_SEG) ? DW'(data_i.second_b_x) - DW'(data_i.second_a_x)
                 : DW'(data_i.second_b_x);
      s1_wy_q <= (op_d == OP_SEG_SEG) ? DW'(data_i.second_b_y) - DW'(data_i.second_a_y)
                 : DW'(data_i.second_b_y);
      s1_dpx_q <= DW'(data_i.first_a_x) - DW'(data_i.second_a_x);
      s1_dpy_q <= DW'(data_i.first_a_y) - DW'(data_i.second_a_y);
      s1_dbx_q <= DW'(data_i.first_b_x) - DW'(data_i.second_a_x);
      s1_dby_q <= DW'(data_i.first_b_y) - DW'(data_i.second_a_y);
      s1_dcx_q <= DW'(data_i.second_b_x) - DW'(data_i.first_a_x);
      s1_dcy_q <= DW'(data_i.second_b_y) - DW'(data_i.first_a_y);
    end
  end

  // ---- stage 2: products
  sli_op_e s2_op_q;
  logic s2_vz_q, s2_wz_q;
  logic signed [CW-1:0] s2_px_q, s2_py_q, s2_qx_q, s2_qy_q;
  logic signed [DW-1:0] s2_wx_q, s2_wy_q;
  logic signed [PW-1:0] m_q [10];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_op_q <= s1_op_q;
      s2_vz_q <= (s1_vx_q == '0) && (s1_vy_q == '0);
      s2_wz_q <= (s1_wx_q == '0) && (s1_wy_q == '0);
      s2_px_q <= s1_px_q;
      s2_py_q <= s1_py_q;
      s2_qx_q <= s1_qx_q;
      s2_qy_q <= s1_qy_q;
      s2_wx_q <= s1_wx_q;
      s2_wy_q <= s1_wy_q;
      m_q[0] <= PW'(s1_wy_q) * PW'(s1_vx_q);
      m_q[1] <= PW'(s1_wx_q) * PW'(s1_vy_q);
      m_q[2] <= PW'(s1_dpy_q) * PW'(s1_vx_q);
      m_q[3] <= PW'(s1_dpx_q) * PW'(s1_vy_q);
      m_q[4] <= PW'(s1_dpy_q) * PW'(s1_wx_q);
      m_q[5] <= PW'(s1_dpx_q) * PW'(s1_wy_q);
      m_q[6] <= PW'(s1_dby_q) * PW'(s1_wx_q);
      m_q[7] <= PW'(s1_dbx_q) * PW'(s1_wy_q);
      m_q[8] <= PW'(s1_dcy_q) * PW'(s1_vx_q);
      m_q[9] <= PW'(s1_dcx_q) * PW'(s1_vy_q);
    end
  end

  // ---- stage 3: cross products
  sli_op_e s3_op_q;
  logic s3_vz_q, s3_wz_q;
  logic signed [CW-1:0] s3_px_q, s3_py_q, s3_qx_q, s3_qy_q;
  logic signed [DW-1:0] s3_wx_q, s3_wy_q;
  logic signed [SW-1:0] s3_wn_q, s3_qpn_q, s3_s1_q, s3_s2_q, s3_s4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_op_q <= s2_op_q;
      s3_vz_q <= s2_vz_q;
      s3_wz_q <= s2_wz_q;
      s3_px_q <= s2_px_q;
      s3_py_q <= s2_py_q;
      s3_qx_q <= s2_qx_q;
      s3_qy_q <= s2_qy_q;
      s3_wx_q <= s2_wx_q;
      s3_wy_q <= s2_wy_q;
      s3_wn_q  <= SW'(m_q[0]) - SW'(m_q[1]);
      s3_qpn_q <= SW'(m_q[2]) - SW'(m_q[3]);
      s3_s1_q  <= SW'(m_q[4]) - SW'(m_q[5]);
      s3_s2_q  <= SW'(m_q[6]) - SW'(m_q[7]);
      s3_s4_q  <= SW'(m_q[8]) - SW'(m_q[9]);
    end
  end

  // ---- stage 4: hit decision, numerator products
  logic hit4_d, par4_d;
  logic signed [CW-1:0] bx4_d, by4_d;
  logic signed [DW-1:0] dx4_d, dy4_d;
  logic signed [SW-1:0] qs4_d, ws4_d;

  always_comb begin
    par4_d = (s3_wn_q == '0);
    hit4_d = (s3_op_q != OP_NONE) && !s3_vz_q && !s3_wz_q;
    if (s3_op_q != OP_LINE_LINE && !straddle(s3_s1_q, s3_s2_q)) hit4_d = 1'b0;
    // second segment test uses -qpn as the start distance
    if (s3_op_q == OP_SEG_SEG && !straddle(-s3_qpn_q, s3_s4_q)) hit4_d = 1'b0;
    if (par4_d && s3_qpn_q != '0) hit4_d = 1'b0;
    bx4_d = par4_d ? s3_px_q : s3_qx_q;
    by4_d = par4_d ? s3_py_q : s3_qy_q;
    dx4_d = par4_d ? '0 : s3_wx_q;
    dy4_d = par4_d ? '0 : s3_wy_q;
    qs4_d = par4_d ? '0 : s3_qpn_q;
    ws4_d = par4_d ? SW'(1) : s3_wn_q;
  end

  logic s4_hit_q;
  logic signed [SW-1:0]  s4_ws_q;
  logic signed [BMW-1:0] s4_bx_q, s4_by_q;
  logic signed [DMW-1:0] s4_dx_q, s4_dy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_hit_q <= hit4_d;
      s4_ws_q  <= ws4_d;
      s4_bx_q  <= BMW'(bx4_d) * BMW'(ws4_d);
      s4_by_q  <= BMW'(by4_d) * BMW'(ws4_d);
      s4_dx_q  <= DMW'(dx4_d) * DMW'(qs4_d);
      s4_dy_q  <= DMW'(dy4_d) * DMW'(qs4_d);
    end
  end

  // ---- stage 5: numerator sum
  logic s5_hit_q;
  logic signed [SW-1:0]   s5_ws_q;
  logic signed [NUMW-1:0] s5_nx_q, s5_ny_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_hit_q <= s4_hit_q;
      s5_ws_q  <= s4_ws_q;
      s5_nx_q  <= NUMW'(s4_bx_q) + NUMW'(s4_dx_q);
      s5_ny_q  <= NUMW'(s4_by_q) + NUMW'(s4_dy_q);
    end
  end

  // ---- stage 6: magnitudes and quotient sign
  logic s6_hit_q, s6_negx_q, s6_negy_q;
  logic [SW-1:0]   s6_d_q;
  logic [NUMW-1:0] s6_mx_q, s6_my_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_hit_q  <= s5_hit_q;
      s6_negx_q <= s5_nx_q[NUMW-1] ^ s5_ws_q[SW-1];
      s6_negy_q <= s5_ny_q[NUMW-1] ^ s5_ws_q[SW-1];
      s6_d_q    <= s5_ws_q[SW-1] ? SW'(-s5_ws_q) : SW'(s5_ws_q);
      s6_mx_q   <= s5_nx_q[NUMW-1] ? NUMW'(-s5_nx_q) : NUMW'(s5_nx_q);
      s6_my_q   <= s5_ny_q[NUMW-1] ? NUMW'(-s5_ny_q) : NUMW'(s5_ny_q);
    end
  end

  // ---- stage 7: scale and add half divisor for round to nearest
  logic s7_hit_q, s7_negx_q, s7_negy_q;
  logic [SW-1:0] s7_d_q;
  logic [NW-1:0] s7_nx_q, s7_ny_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s7_hit_q  <= s6_hit_q;
      s7_negx_q <= s6_negx_q;
      s7_negy_q <= s6_negy_q;
      s7_d_q    <= s6_d_q;
      s7_nx_q   <= (NW'(s6_mx_q) << FRAC_BITS) + NW'(s6_d_q >> 1);
      s7_ny_q   <= (NW'(s6_my_q) << FRAC_BITS) + NW'(s6_d_q >> 1);
    end
  end

  // ---- stage 8: quotient overflow check (q >= 2^QW)
  logic [XW-1:0] dlim;
  logic s8_hit_q, s8_negx_q, s8_negy_q, s8_ovfx_q, s8_ovfy_q;

  assign dlim = XW'(s7_d_q) << QW;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s8_hit_q  <= s7_hit_q;
      s8_negx_q <= s7_negx_q;
      s8_negy_q <= s7_negy_q;
      s8_ovfx_q <= XW'(s7_nx_q) >= dlim;
      s8_ovfy_q <= XW'(s7_ny_q) >= dlim;
      nx_o      <= s7_nx_q;
      ny_o      <= s7_ny_q;
      d_o       <= s7_d_q;
    end
  end

  assign ctl_o = '{valid: vld_q[7], hit: s8_hit_q, neg_x: s8_negx_q, neg_y: s8_negy_q,
                   ovf_x: s8_ovfx_q, ovf_y: s8_ovfy_q};

endmodule

// ===== design/sli_div_cell.sv =====
`timescale 1ns / 1ps
module sli_div_cell #(
  parameter int NW    = 62,
  parameter int SHIFT = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  sli_pkg::sli_ctl_t        ctl_i,
  input  logic [NW-1:0]            rx_i,
  input  logic [NW-1:0]            ry_i,
  input  logic [sli_pkg::QW-1:0]   qx_i,
  input  logic [sli_pkg::QW-1:0]   qy_i,
  input  logic [sli_pkg::SW-1:0]   d_i,
  output sli_pkg::sli_ctl_t        ctl_o,
  output logic [NW-1:0]            rx_o,
  output logic [NW-1:0]            ry_o,
  output logic [sli_pkg::QW-1:0]   qx_o,
  output logic [sli_pkg::QW-1:0]   qy_o,
  output logic [sli_pkg::SW-1:0]   d_o
);
  import sli_pkg::*;

  localparam int XW = NW + QW;

  logic [XW-1:0] dsh;
  logic          gex, gey;
  logic          vld_q, hit_q, negx_q, negy_q, ovfx_q, ovfy_q;

  // one restoring step per coordinate
  assign dsh = XW'(d_i) << SHIFT;
  assign gex = XW'(rx_i) >= dsh;
  assign gey = XW'(ry_i) >= dsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= ctl_i.hit;
      negx_q <= ctl_i.neg_x;
      negy_q <= ctl_i.neg_y;
      ovfx_q <= ctl_i.ovf_x;
      ovfy_q <= ctl_i.ovf_y;
      rx_o <= gex ? NW'(XW'(rx_i) - dsh) : rx_i;
      ry_o <= gey ? NW'(XW'(ry_i) - dsh) : ry_i;
      qx_o <= qx_i | (QW'(gex) << SHIFT);
      qy_o <= qy_i | (QW'(gey) << SHIFT);
      d_o  <= d_i;
    end
  end

  assign ctl_o = '{valid: vld_q, hit: hit_q, neg_x: negx_q, neg_y: negy_q,
                   ovf_x: ovfx_q, ovf_y: ovfy_q};

endmodule
